// ----- sv/des_dk_pkg.sv -----
// ----------------------------------------------------------------------------
// des_dk_pkg
// Shared types, permutation tables and helper functions for the DES
// decryption key schedule: PC-1, PC-2 and the per-round rotation amounts.
// ----------------------------------------------------------------------------
package des_dk_pkg;

    localparam int KEY_BITS    = 64;
    localparam int HALF_BITS   = 28;
    localparam int CD_BITS     = 56;
    localparam int SUBKEY_BITS = 48;
    localparam int NUM_ROUNDS  = 16;
    localparam int ROUND_W     = 5;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(1);

    typedef logic [CD_BITS-1:0]     t_cd;
    typedef logic [HALF_BITS-1:0]   t_half;
    typedef logic [SUBKEY_BITS-1:0] t_subkey;
    typedef logic [ROUND_W-1:0]     t_round;

    typedef struct packed {
        logic   valid;
        t_round round;
        t_cd    cd;
    } t_emit;

    localparam logic [6:0] PC1_TAB [CD_BITS] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [SUBKEY_BITS] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // left rotation of rounds 1..16
    localparam logic [1:0] ROT_TAB [NUM_ROUNDS] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    function automatic t_cd pc1(input logic [KEY_BITS-1:0] key);
        t_cd r;
        for (int i = 0; i < CD_BITS; i++) begin
            r[CD_BITS-1-i] = key[KEY_BITS - int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic t_subkey pc2(input t_cd cd);
        t_subkey r;
        for (int i = 0; i < SUBKEY_BITS; i++) begin
            r[SUBKEY_BITS-1-i] = cd[CD_BITS - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic t_half rot_right(input t_half v, input logic [1:0] s);
        t_half r;
        if (s == 2'd2) begin
            r = {v[1:0], v[HALF_BITS-1:2]};
        end else begin
            r = {v[0], v[HALF_BITS-1:1]};
        end
        return r;
    endfunction

endpackage

// ----- sv/des_decrypt_key_schedule_unit.sv -----
// ----------------------------------------------------------------------------
// des_decrypt_key_schedule_unit
// DES key schedule in decryption order: one 64-bit key in, sixteen PC-2
// round keys out, K16 first and K1 last, the last one flagged.
//
//   channel  direction  handshake            payload
//   key      in         i_valid / o_ready    i_master_key
//   subkey   out        o_valid / i_ready    o_round_number, o_subkey, o_last_key
//
// A key walks a row of sixteen round cells, one cell per cycle unless the
// output stalls; each cell emits one round key, and the next key enters
// in the cycle its predecessor's round 1 leaves the row.
// The first round key passes the first cell and then the output register.
// A stall on the output freezes the whole row and the output register.
// Reset clears the cell and output valid bits only.
// ----------------------------------------------------------------------------
module des_decrypt_key_schedule_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [63:0]         i_master_key,
    output logic                o_valid,
    input  logic                i_ready,
    output des_dk_pkg::t_round  o_round_number,
    output des_dk_pkg::t_subkey o_subkey,
    output logic                o_last_key
);
    import des_dk_pkg::*;

    logic                  adv;
    logic                  accept;
    logic [NUM_ROUNDS-1:0] cell_valid;
    t_cd                   cell_cd      [NUM_ROUNDS];
    t_cd                   cell_cd_next [NUM_ROUNDS];
    t_emit                 emit;

    assign o_ready = adv && !(|cell_valid[NUM_ROUNDS-2:0]);
    assign accept  = i_valid && o_ready;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        if (g == 0) begin : g_head
            des_dk_cell #(.CELL_IDX(g)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (adv),
                .i_valid  (accept),
                .i_cd     (pc1(i_master_key)),
                .o_valid  (cell_valid[g]),
                .o_cd     (cell_cd[g]),
                .o_cd_next(cell_cd_next[g])
            );
        end else begin : g_body
            des_dk_cell #(.CELL_IDX(g)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (adv),
                .i_valid  (cell_valid[g-1]),
                .i_cd     (cell_cd_next[g-1]),
                .o_valid  (cell_valid[g]),
                .o_cd     (cell_cd[g]),
                .o_cd_next(cell_cd_next[g])
            );
        end
    end

    // select the active cell
    always_comb begin
        emit = '0;
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            if (cell_valid[i]) begin
                emit.valid = 1'b1;
                emit.round = emit.round | ROUND_W'(NUM_ROUNDS - i);
                emit.cd    = emit.cd | cell_cd[i];
            end
        end
    end

    des_dk_outreg u_outreg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (emit),
        .i_ready       (i_ready),
        .o_adv         (adv),
        .o_valid       (o_valid),
        .o_round_number(o_round_number),
        .o_subkey      (o_subkey),
        .o_last_key    (o_last_key)
    );

    a_one_active_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_valid))
        else $error("more than one round cell active");

    a_key_enters_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> cell_valid[0])
        else $error("accepted key missing from first cell");

    a_rounds_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_key |=>
            o_valid && (o_round_number == $past(o_round_number) - ROUND_W'(1)))
        else $error("round keys not contiguous and descending");

endmodule

// ----- sv/des_dk_cell.sv -----
// ----------------------------------------------------------------------------
// des_dk_cell
// One round cell: holds the C/D halves of its round and hands the halves
// of the previous round, rotated right, to the next cell on each advance.
// ----------------------------------------------------------------------------
module des_dk_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  des_dk_pkg::t_cd i_cd,
    output logic            o_valid,
    output des_dk_pkg::t_cd o_cd,
    output des_dk_pkg::t_cd o_cd_next
);
    import des_dk_pkg::*;

    localparam logic [1:0] ROT = ROT_TAB[NUM_ROUNDS - 1 - CELL_IDX];

    logic r_valid;
    t_cd  r_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_cd <= i_cd;
        end
    end

    assign o_valid   = r_valid;
    assign o_cd      = r_cd;
    assign o_cd_next = {rot_right(r_cd[CD_BITS-1:HALF_BITS], ROT),
                        rot_right(r_cd[HALF_BITS-1:0], ROT)};

endmodule

// ----- sv/des_dk_outreg.sv -----
// ----------------------------------------------------------------------------
// des_dk_outreg
// Output register: applies PC-2 to the active cell's halves and holds the
// result word until the consumer takes it; drives the chain advance.
// ----------------------------------------------------------------------------
module des_dk_outreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  des_dk_pkg::t_emit   i_emit,
    input  logic                i_ready,
    output logic                o_adv,
    output logic                o_valid,
    output des_dk_pkg::t_round  o_round_number,
    output des_dk_pkg::t_subkey o_subkey,
    output logic                o_last_key
);
    import des_dk_pkg::*;

    logic    r_valid;
    t_round  r_round;
    t_subkey r_subkey;
    logic    r_last;

    assign o_adv = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_emit.valid) begin
            r_round  <= i_emit.round;
            r_subkey <= pc2(i_emit.cd);
            r_last   <= (i_emit.round == FIRST_ROUND);
        end
    end

    assign o_valid        = r_valid;
    assign o_round_number = r_round;
    assign o_subkey       = r_subkey;
    assign o_last_key     = r_last;

endmodule
